// ===== rtl/lru_tag_cache_assert.svh =====
// Assertion macros used by the checker of the LRU tag cache.
// Both expect a signal named clock in the scope of use; LRC_ASSERT also expects reset.
`ifndef LRU_TAG_CACHE_ASSERT_SVH
`define LRU_TAG_CACHE_ASSERT_SVH

// Check on every clock edge outside reset.
`define LRC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check on every clock edge, reset included.
`define LRC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== rtl/lrc_pkg.sv =====
// Shared widths, codes and types for the LRU tag cache.
// No dependencies; every other file but the assertion header imports this package.
package lrc_pkg;

   localparam int unsigned DEF_ENTRIES = 16;

   localparam int unsigned CAP_W  = 5;
   localparam int unsigned TAG_W  = 32;
   localparam int unsigned DIM_W  = 12;
   localparam int unsigned KEY_W  = TAG_W + 2 * DIM_W;
   localparam int unsigned SLOT_W = 4;
   localparam int unsigned CNT_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0] count_type;

endpackage

// ===== rtl/lrc_chan_if.sv =====
// Request and response channel interfaces of the LRU tag cache.
// Depends on lrc_pkg for field widths.
interface lrc_req_if;
   import lrc_pkg::*;

   logic             valid;
   logic             ready;
   logic             kind;
   logic [TAG_W-1:0] sprite_tag;
   logic [DIM_W-1:0] target_width;
   logic [DIM_W-1:0] target_height;

   modport source (output valid, kind, sprite_tag, target_width, target_height,
                   input ready);
   modport sink   (input valid, kind, sprite_tag, target_width, target_height,
                   output ready);
endinterface

interface lrc_rsp_if;
   import lrc_pkg::*;

   logic              valid;
   logic              ready;
   logic              hit;
   logic [SLOT_W-1:0] slot;
   logic              evicted;
   logic [CNT_W-1:0]  hit_total;
   logic [CNT_W-1:0]  miss_total;

   modport source (output valid, hit, slot, evicted, hit_total, miss_total,
                   input ready);
   modport sink   (input valid, hit, slot, evicted, hit_total, miss_total,
                   output ready);
endinterface

// ===== rtl/lru_tag_cache.sv =====
// Fully associative LRU tag directory with hit and miss counters.
// Depends on lrc_pkg and the channel interfaces in lrc_chan_if.sv.
//
//   channel   direction  handshake          word
//   req_bus   in         valid/ready        kind, sprite_tag, target_width, target_height
//   rsp_bus   out        valid/ready        hit, slot, evicted, hit_total, miss_total
//   csr_*     in         csr_wr_en only     capacity (5 bits)
//
// One word per cycle sustained while rsp ready stays high; a request is held in the
// request register, then its result in the result register. The tag compare, age-rank
// update and counter increment are combinational between the two registers.
// Synchronous reset clears the valid bits, occupancy, counters and sets capacity to 16.
// With rsp ready low the result holds and the request register still takes one word.
module lru_tag_cache #(
   parameter int unsigned ENTRIES = lrc_pkg::DEF_ENTRIES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [lrc_pkg::CAP_W-1:0] csr_wr_data,
   lrc_req_if.sink                  req_bus,
   lrc_rsp_if.source                rsp_bus
);
   import lrc_pkg::*;

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
   localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   // request register
   logic              in_valid_ff, in_valid_in;
   logic              in_kind_ff;
   key_type           in_key_ff;

   // directory state
   logic [ENTRIES-1:0] valid_ff, valid_in;
   key_type            key_ff  [ENTRIES];
   logic [IDX_W-1:0]   rank_ff [ENTRIES];
   logic [IDX_W-1:0]   rank_in [ENTRIES];
   logic [OCC_W-1:0]   occ_ff, occ_in;
   count_type          hit_cnt_ff, hit_cnt_in;
   count_type          miss_cnt_ff, miss_cnt_in;
   logic [CAP_W-1:0]   cap_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_evicted_ff;
   count_type         rsp_hit_total_ff;
   count_type         rsp_miss_total_ff;

   logic advance, take, lookup, write_key;
   logic [ENTRIES-1:0] match, old_match;
   logic hit_any, full, evict;
   logic [IDX_W-1:0] hit_idx, free_idx, old_idx, new_slot, hit_rank, oldest_rank;
   logic [OCC_W-1:0] occ_m1;
   logic [CMP_W-1:0] eff_cap;
   logic [SLOT_W+IDX_W-1:0] slot_wide;
   logic [SLOT_W-1:0] res_slot;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;
   assign lookup        = advance && (in_kind_ff == KIND_LOOKUP);

   assign in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // tag compare and priority picks
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      old_idx  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]     = valid_ff[i] && (key_ff[i] == in_key_ff);
         old_match[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
         if (old_match[i]) begin
            old_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any     = |match;
   assign occ_m1      = occ_ff - OCC_W'(1);
   assign oldest_rank = occ_m1[IDX_W-1:0];

   always_comb begin
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (IDX_W'(i) == hit_idx) begin
            hit_rank = rank_ff[i];
         end
      end
   end

   // capacity zero acts as one, above the entry count it saturates
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign full      = CMP_W'(occ_ff) >= eff_cap;
   assign evict     = !hit_any && full;
   assign new_slot  = hit_any ? hit_idx : (full ? old_idx : free_idx);
   assign write_key = lookup && !hit_any;
   assign slot_wide = {{SLOT_W{1'b0}}, new_slot};
   assign res_slot  = (in_kind_ff == KIND_CLEAR) ? '0 : slot_wide[SLOT_W-1:0];

   // next directory state
   always_comb begin
      valid_in    = valid_ff;
      occ_in      = occ_ff;
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (advance && (in_kind_ff == KIND_CLEAR)) begin
         valid_in = '0;
         occ_in   = '0;
      end else if (lookup) begin
         if (hit_any) begin
            hit_cnt_in = hit_cnt_ff + CNT_W'(1);
         end else begin
            miss_cnt_in = miss_cnt_ff + CNT_W'(1);
            if (!full) begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end
         for (int i = 0; i < ENTRIES; i++) begin
            // age valid entries younger than the hit or evicted rank, or all of them on a miss with room
            if (IDX_W'(i) == new_slot) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] &&
                         (hit_any ? (rank_ff[i] < hit_rank) :
                          evict   ? (rank_ff[i] < oldest_rank) : 1'b1)) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         valid_in[new_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         cap_ff       <= CAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_kind_ff <= req_bus.kind;
         in_key_ff  <= {req_bus.sprite_tag, req_bus.target_width, req_bus.target_height};
      end
      for (int i = 0; i < ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
      end
      if (write_key) begin
         key_ff[new_slot] <= in_key_ff;
      end
      if (advance) begin
         rsp_hit_ff        <= lookup && hit_any;
         rsp_slot_ff       <= res_slot;
         rsp_evicted_ff    <= lookup && evict;
         rsp_hit_total_ff  <= hit_cnt_in;
         rsp_miss_total_ff <= miss_cnt_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hit        = rsp_hit_ff;
   assign rsp_bus.slot       = rsp_slot_ff;
   assign rsp_bus.evicted    = rsp_evicted_ff;
   assign rsp_bus.hit_total  = rsp_hit_total_ff;
   assign rsp_bus.miss_total = rsp_miss_total_ff;

endmodule

// ===== rtl/lrc_checker.sv =====
// Port-level checks on the response channel of the LRU tag cache.
// Depends on lrc_pkg and lru_tag_cache_assert.svh; bound to lru_tag_cache below.
`include "lru_tag_cache_assert.svh"

module lrc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_hit,
   input logic [lrc_pkg::SLOT_W-1:0] rsp_slot,
   input logic                      rsp_evicted,
   input logic [lrc_pkg::CNT_W-1:0]  rsp_hit_total,
   input logic [lrc_pkg::CNT_W-1:0]  rsp_miss_total
);
   import lrc_pkg::*;

   count_type prev_hit_ff, prev_miss_ff;
   count_type hit_step, miss_step;
   logic      rsp_take;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign hit_step  = rsp_hit_total - prev_hit_ff;
   assign miss_step = rsp_miss_total - prev_miss_ff;

   // hold the totals of the last word taken
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_hit_ff  <= '0;
         prev_miss_ff <= '0;
      end else if (rsp_take) begin
         prev_hit_ff  <= rsp_hit_total;
         prev_miss_ff <= rsp_miss_total;
      end
   end

   `LRC_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "response valid after reset")

   `LRC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_hit_total), "stalled response changed")

   `LRC_ASSERT(a_count_step, rsp_take |-> (hit_step == '0 && miss_step == '0) || (hit_step == CNT_W'(1) && miss_step == '0) || (hit_step == '0 && miss_step == CNT_W'(1)), "counters moved by more than one item")

   `LRC_ASSERT(a_hit_count, rsp_take && rsp_hit |-> hit_step == CNT_W'(1) && !rsp_evicted, "hit without hit count step")

   `LRC_ASSERT(a_evict_miss, rsp_take && rsp_evicted |-> miss_step == CNT_W'(1), "eviction without miss count step")

endmodule

bind lru_tag_cache lrc_checker u_lrc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_hit        (rsp_bus.hit),
   .rsp_slot       (rsp_bus.slot),
   .rsp_evicted    (rsp_bus.evicted),
   .rsp_hit_total  (rsp_bus.hit_total),
   .rsp_miss_total (rsp_bus.miss_total)
);
